>>> src/tef_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tef_pkg;

  // Fixed field widths
  localparam int CMD_W  = 2;
  localparam int ID_W   = 4;
  localparam int DATA_W = 32;
  localparam int PEND_W = 7;
  localparam int STAT_W = 2;

  // Defaults for the top-level parameters
  localparam int DEPTH_DEF     = 64;
  localparam int NUM_TYPES_DEF = 16;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_HALTED = 2'd2
  } status_t;

  // One queue entry
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [DATA_W-1:0] aux;
    logic [DATA_W-1:0] stamp;
  } entry_t;

  // Result of the control pass, carried to the output stage
  typedef struct packed {
    status_t           status;
    logic              pop_ok;
    logic [PEND_W-1:0] pending;
    logic [DATA_W-1:0] count;
  } res_meta_t;

endpackage

`default_nettype wire

>>> src/tef_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module tef_mem #(
  parameter int DEPTH = tef_pkg::DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire tef_pkg::entry_t          wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output tef_pkg::entry_t               rdata
);
  import tef_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_r;

  // Single write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> src/tef_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module tef_ctrl #(
  parameter int DEPTH     = tef_pkg::DEPTH_DEF,
  parameter int NUM_TYPES = tef_pkg::NUM_TYPES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         acc,
  input  wire logic [tef_pkg::CMD_W-1:0]    cmd,
  input  wire logic [tef_pkg::ID_W-1:0]     event_id,
  input  wire logic [tef_pkg::DATA_W-1:0]   aux_data,
  input  wire logic [tef_pkg::DATA_W-1:0]   now_us,
  output logic                              mem_we,
  output logic [$clog2(DEPTH)-1:0]          mem_waddr,
  output tef_pkg::entry_t                   mem_wdata,
  output logic                              mem_re,
  output logic [$clog2(DEPTH)-1:0]          mem_raddr,
  output tef_pkg::res_meta_t                meta
);
  import tef_pkg::*;

  localparam int AW      = $clog2(DEPTH);
  localparam int OCC_W   = $clog2(DEPTH + 1);
  // Only types reachable by a 4-bit id need a counter
  localparam int NUM_CTR = (NUM_TYPES < (1 << ID_W)) ? NUM_TYPES : (1 << ID_W);
  localparam int CIDX_W  = $clog2(NUM_CTR);

  logic [AW-1:0]     wr_r, wr_nxt;
  logic [AW-1:0]     rd_r, rd_nxt;
  logic [OCC_W-1:0]  occ_r, occ_nxt;
  logic              halted_r, halted_nxt;
  logic [DATA_W-1:0] cnt_r   [NUM_CTR];
  logic [DATA_W-1:0] cnt_nxt [NUM_CTR];

  logic              full;
  logic              empty;
  logic              id_ok;
  logic [CIDX_W-1:0] cidx;
  logic [OCC_W-1:0]  occ_inc;
  logic              push_ok;
  logic              pop_ok;

  assign full    = (occ_r == OCC_W'(DEPTH));
  assign empty   = (occ_r == '0);
  assign id_ok   = (32'(event_id) < NUM_CTR);
  assign cidx    = event_id[CIDX_W-1:0];
  assign occ_inc = occ_r + OCC_W'(1);

  // One pass over the command against the current state
  always_comb begin
    wr_nxt       = wr_r;
    rd_nxt       = rd_r;
    occ_nxt      = occ_r;
    halted_nxt   = halted_r;
    cnt_nxt      = cnt_r;
    push_ok      = 1'b0;
    pop_ok       = 1'b0;
    meta.status  = ST_OK;
    meta.pop_ok  = 1'b0;
    meta.pending = PEND_W'(occ_r);
    meta.count   = '0;
    if (halted_r) begin
      meta.status  = ST_HALTED;
      meta.pending = '0;
    end else begin
      unique case (cmd)
        CMD_PUSH: begin
          if (full) begin
            halted_nxt   = 1'b1;
            meta.status  = ST_HALTED;
            meta.pending = '0;
          end else begin
            push_ok      = 1'b1;
            wr_nxt       = (wr_r == AW'(DEPTH - 1)) ? '0 : wr_r + AW'(1);
            occ_nxt      = occ_inc;
            meta.pending = PEND_W'(occ_inc);
            if (id_ok && (event_id != '0)) begin
              cnt_nxt[cidx] = cnt_r[cidx] + DATA_W'(1);
              cnt_nxt[0]    = cnt_r[0] + DATA_W'(1);
            end
          end
        end
        CMD_POP: begin
          if (empty) begin
            meta.status  = ST_EMPTY;
            meta.pending = '0;
          end else begin
            pop_ok      = 1'b1;
            meta.pop_ok = 1'b1;
            rd_nxt      = (rd_r == AW'(DEPTH - 1)) ? '0 : rd_r + AW'(1);
            occ_nxt     = occ_r - OCC_W'(1);
          end
        end
        CMD_QUERY: begin
          meta.count = id_ok ? cnt_r[cidx] : '0;
        end
        default: begin
          // unused code: report occupancy only
        end
      endcase
    end
  end

  // Entry store access
  assign mem_we    = acc && push_ok;
  assign mem_waddr = wr_r;
  assign mem_wdata = '{id: event_id, aux: aux_data, stamp: now_us};
  assign mem_re    = acc && pop_ok;
  assign mem_raddr = rd_r;

  // State registers, updated on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r     <= '0;
      rd_r     <= '0;
      occ_r    <= '0;
      halted_r <= 1'b0;
      for (int i = 0; i < NUM_CTR; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (acc) begin
      wr_r     <= wr_nxt;
      rd_r     <= rd_nxt;
      occ_r    <= occ_nxt;
      halted_r <= halted_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Expected write position from read position and fill level
  logic [OCC_W:0] wr_sum;
  logic [OCC_W:0] wr_exp;
  assign wr_sum = (OCC_W + 1)'(rd_r) + (OCC_W + 1)'(occ_r);
  assign wr_exp = (wr_sum >= (OCC_W + 1)'(DEPTH)) ? wr_sum - (OCC_W + 1)'(DEPTH) : wr_sum;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(DEPTH))
    else $error("occupancy above depth");

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r && $stable(occ_r) && $stable(cnt_r[0]))
    else $error("state changed while halted");

  a_idx_track: assert property (@(posedge clk) disable iff (!rst_n)
    (OCC_W + 1)'(wr_r) == wr_exp)
    else $error("write index out of step with read index and occupancy");

endmodule

`default_nettype wire

>>> src/tef_out.sv
`timescale 1ns / 1ps
`default_nettype none

module tef_out (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        acc,
  input  wire tef_pkg::res_meta_t          meta,
  input  wire tef_pkg::entry_t             rdata,
  input  wire logic                        out_stall,
  output logic                             in_stall,
  output logic                             out_valid,
  output logic [tef_pkg::STAT_W-1:0]       out_status,
  output logic [tef_pkg::ID_W-1:0]         out_event_id,
  output logic [tef_pkg::DATA_W-1:0]       out_aux_data,
  output logic [tef_pkg::DATA_W-1:0]       out_timestamp,
  output logic [tef_pkg::PEND_W-1:0]       out_pending_count,
  output logic [tef_pkg::DATA_W-1:0]       out_event_count
);
  import tef_pkg::*;

  logic              s1_valid_r;
  res_meta_t         s1_meta_r;
  logic              s1_adv;
  logic              out_valid_r;
  logic [STAT_W-1:0] status_r;
  entry_t            entry_r;
  logic [PEND_W-1:0] pend_r;
  logic [DATA_W-1:0] count_r;

  // Stage 1 moves on whenever the result register is free or being emptied
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;

  // Stage 1 valid: control result waits here for the entry read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_meta_r <= meta;
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload: entry fields only for a successful pop
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      status_r <= s1_meta_r.status;
      entry_r  <= s1_meta_r.pop_ok ? rdata : '0;
      pend_r   <= s1_meta_r.pending;
      count_r  <= s1_meta_r.count;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_event_id      = entry_r.id;
  assign out_aux_data      = entry_r.aux;
  assign out_timestamp     = entry_r.stamp;
  assign out_pending_count = pend_r;
  assign out_event_count   = count_r;

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_meta_r))
    else $error("stage 1 result dropped or changed while blocked");

  a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("stage 1 transfer did not reach the result register");

  a_no_accept_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r && s1_valid_r)
    else $error("input blocked with free pipeline slot");

endmodule

`default_nettype wire

>>> src/timestamped_event_fifo_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Payload
// in_       input      in_valid/in_stall    in_cmd, in_event_id, in_aux_data, in_now_us
// out_      output     out_valid/out_stall  out_status, out_event_id, out_aux_data,
//                                           out_timestamp, out_pending_count,
//                                           out_event_count
//
// One item per clock sustained while out_stall stays low; every item gives exactly one result.
// After its transfer a result is registered first in stage 1, where the entry store's
// registered read port delivers the entry, and then in the result register.
// rst_n is synchronous; it clears indices, occupancy, counters and the halt
// flag at once. The entry store is not cleared.
// out_stall holds the result register; in_stall rises only when both stages are full.

module timestamped_event_fifo_top #(
  parameter int DEPTH     = tef_pkg::DEPTH_DEF,
  parameter int NUM_TYPES = tef_pkg::NUM_TYPES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [tef_pkg::CMD_W-1:0]   in_cmd,
  input  wire logic [tef_pkg::ID_W-1:0]    in_event_id,
  input  wire logic [tef_pkg::DATA_W-1:0]  in_aux_data,
  input  wire logic [tef_pkg::DATA_W-1:0]  in_now_us,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [tef_pkg::STAT_W-1:0]       out_status,
  output logic [tef_pkg::ID_W-1:0]         out_event_id,
  output logic [tef_pkg::DATA_W-1:0]       out_aux_data,
  output logic [tef_pkg::DATA_W-1:0]       out_timestamp,
  output logic [tef_pkg::PEND_W-1:0]       out_pending_count,
  output logic [tef_pkg::DATA_W-1:0]       out_event_count
);
  import tef_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic      acc;
  logic      mem_we;
  logic      mem_re;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  entry_t    mem_wdata;
  entry_t    mem_rdata;
  res_meta_t meta;

  // Input transfer
  assign acc = in_valid && !in_stall;

  tef_ctrl #(
    .DEPTH     (DEPTH),
    .NUM_TYPES (NUM_TYPES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .cmd       (in_cmd),
    .event_id  (in_event_id),
    .aux_data  (in_aux_data),
    .now_us    (in_now_us),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .meta      (meta)
  );

  tef_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  tef_out u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .acc               (acc),
    .meta              (meta),
    .rdata             (mem_rdata),
    .out_stall         (out_stall),
    .in_stall          (in_stall),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_event_id      (out_event_id),
    .out_aux_data      (out_aux_data),
    .out_timestamp     (out_timestamp),
    .out_pending_count (out_pending_count),
    .out_event_count   (out_event_count)
  );

endmodule

`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import tef_pkg::*;

  localparam int DEPTH     = DEPTH_DEF;
  localparam int NUM_TYPES = NUM_TYPES_DEF;

  // cmd encoding that the block treats as a no-op
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  localparam int RAND_ITEMS       = 210;
  localparam int LONG_HOLD_AT     = 150;
  localparam int LONG_HOLD_CYCLES = 60;
  localparam int SETTLE_CYCLES    = 8;
  localparam int WATCHDOG_LIMIT   = 2000;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [ID_W-1:0]   id;
    logic [DATA_W-1:0] aux;
    logic [DATA_W-1:0] now;
    bit                drain_first;  // hold until nothing is in flight
  } evt_req_t;

  typedef struct {
    status_t           status;
    logic [ID_W-1:0]   id;
    logic [DATA_W-1:0] aux;
    logic [DATA_W-1:0] stamp;
    logic [PEND_W-1:0] pend;
    logic [DATA_W-1:0] count;
  } evt_reply_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [CMD_W-1:0]  in_cmd = '0;
  logic [ID_W-1:0]   in_event_id = '0;
  logic [DATA_W-1:0] in_aux_data = '0;
  logic [DATA_W-1:0] in_now_us = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [STAT_W-1:0] out_status;
  logic [ID_W-1:0]   out_event_id;
  logic [DATA_W-1:0] out_aux_data;
  logic [DATA_W-1:0] out_timestamp;
  logic [PEND_W-1:0] out_pending_count;
  logic [DATA_W-1:0] out_event_count;

  timestamped_event_fifo_top #(
    .DEPTH     (DEPTH),
    .NUM_TYPES (NUM_TYPES)
  ) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_event_id       (in_event_id),
    .in_aux_data       (in_aux_data),
    .in_now_us         (in_now_us),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_event_id      (out_event_id),
    .out_aux_data      (out_aux_data),
    .out_timestamp     (out_timestamp),
    .out_pending_count (out_pending_count),
    .out_event_count   (out_event_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the event queue and its counters
  entry_t            ring_mem [DEPTH];
  int unsigned       ring_wr;
  int unsigned       ring_rd;
  int unsigned       ring_fill;
  logic [DATA_W-1:0] type_tally [NUM_TYPES];
  bit                halted_seen;

  evt_req_t   stim_q [$];
  evt_reply_t awaited_replies [$];
  int         gen_fill;
  int         tail_len;
  int         err_count;

  logic tail_quiet   = 1'b0;
  logic rx_long_hold = 1'b0;

  // Reply for one transfer; advances the shadow state
  function automatic evt_reply_t predict_reply(evt_req_t req);
    evt_reply_t  r;
    int unsigned occ_before;
    r = '{status: ST_OK, id: '0, aux: '0, stamp: '0, pend: '0, count: '0};
    if (halted_seen) begin
      r.status = ST_HALTED;
      return r;
    end
    case (req.cmd)
      CMD_PUSH: begin
        if (ring_fill >= DEPTH) begin
          // overflow: sticky halt, nothing stored
          halted_seen = 1'b1;
          r.status = ST_HALTED;
        end else begin
          ring_mem[ring_wr] = '{id: req.id, aux: req.aux, stamp: req.now};
          if (req.id != 0 && int'(req.id) < NUM_TYPES) begin
            type_tally[req.id]++;
            type_tally[0]++;
          end
          ring_wr = (ring_wr + 1) % DEPTH;
          ring_fill++;
          r.pend = PEND_W'(ring_fill);
        end
      end
      CMD_POP: begin
        if (ring_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          occ_before = ring_fill;
          r.id = ring_mem[ring_rd].id;
          r.aux = ring_mem[ring_rd].aux;
          r.stamp = ring_mem[ring_rd].stamp;
          ring_rd = (ring_rd + 1) % DEPTH;
          ring_fill--;
          r.pend = PEND_W'(occ_before);
        end
      end
      CMD_QUERY: begin
        if (int'(req.id) < NUM_TYPES) r.count = type_tally[req.id];
        r.pend = PEND_W'(ring_fill);
      end
      default: begin
        r.pend = PEND_W'(ring_fill);
      end
    endcase
    return r;
  endfunction

  // Mostly random words, with the all-zero and all-one extremes now and then
  function automatic logic [DATA_W-1:0] rand_word();
    int pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return $urandom;
  endfunction

  // Append one item and track the fill level it leaves behind
  function automatic void queue_req(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                                    logic [DATA_W-1:0] aux, logic [DATA_W-1:0] now,
                                    bit drain_first);
    evt_req_t q;
    q.cmd = cmd;
    q.id = id;
    q.aux = aux;
    q.now = now;
    q.drain_first = drain_first;
    stim_q.push_back(q);
    if (cmd == CMD_PUSH && gen_fill < DEPTH) gen_fill++;
    else if (cmd == CMD_POP && gen_fill > 0) gen_fill--;
  endfunction

  function automatic void cmp_field(string fname, logic [DATA_W-1:0] want,
                                    logic [DATA_W-1:0] got);
    if (want !== got) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
    end
  endfunction

  // Driver: presents queued items, predicts each reply at its transfer
  evt_req_t cur_req;
  int       idle_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      idle_left = 0;
    end else begin
      if (in_valid && !in_stall) awaited_replies.push_back(predict_reply(cur_req));
      if (!(in_valid && in_stall)) begin
        if (idle_left > 0) begin
          idle_left--;
          in_valid <= 1'b0;
        end else if (stim_q.size() == 0 ||
                     (stim_q[0].drain_first && awaited_replies.size() != 0)) begin
          in_valid <= 1'b0;
        end else if (stim_q.size() > tail_len && !rx_long_hold &&
                     $urandom_range(0, 7) == 0) begin
          idle_left = $urandom_range(0, 3);
          in_valid <= 1'b0;
        end else begin
          cur_req = stim_q.pop_front();
          in_valid <= 1'b1;
          in_cmd <= cur_req.cmd;
          in_event_id <= cur_req.id;
          in_aux_data <= cur_req.aux;
          in_now_us <= cur_req.now;
        end
      end
      tail_quiet <= (stim_q.size() <= tail_len);
    end
  end

  // Monitor: checks each result transfer, drives out_stall
  int replies_seen = 0;
  int long_left = 0;
  int burst_left = 0;
  bit long_done = 1'b0;

  always @(posedge clk) begin
    evt_reply_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_long_hold <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_replies.size() == 0) begin
          err_count++;
          $display("%0t: result with none expected, actual status %0h", $time, out_status);
        end else begin
          want = awaited_replies.pop_front();
          replies_seen++;
          cmp_field("status", want.status, out_status);
          cmp_field("event_id", want.id, out_event_id);
          cmp_field("aux_data", want.aux, out_aux_data);
          cmp_field("timestamp", want.stamp, out_timestamp);
          cmp_field("pending_count", want.pend, out_pending_count);
          cmp_field("event_count", want.count, out_event_count);
        end
      end

      // one long hold-off so the block backs up into in_stall
      if (long_left == 0 && !long_done && replies_seen >= LONG_HOLD_AT) begin
        long_done = 1'b1;
        long_left = LONG_HOLD_CYCLES;
      end
      if (long_left > 0) begin
        long_left--;
        out_stall <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        out_stall <= 1'b1;
      end else if (!tail_quiet && $urandom_range(0, 6) == 0) begin
        burst_left = $urandom_range(0, 3);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
      rx_long_hold <= (long_left > 0);
    end
  end

  // Watchdog on cycles without any transfer
  int stuck_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    int               mode;
    int               left;
    int               pick;
    int               push_pct;
    int               pop_pct;
    logic [CMD_W-1:0] c;

    // shadow state after reset
    ring_wr = 0;
    ring_rd = 0;
    ring_fill = 0;
    halted_seen = 1'b0;
    for (int i = 0; i < NUM_TYPES; i++) type_tally[i] = '0;
    err_count = 0;
    gen_fill = 0;
    tail_len = 0;

    // Directed: empty pop, zero counters, id and word extremes, spare code, order
    queue_req(CMD_POP, 4'h0, '0, '0, 1'b0);
    queue_req(CMD_QUERY, 4'h0, '0, '0, 1'b0);
    queue_req(CMD_PUSH, 4'h0, '0, '0, 1'b0);  // type 0: stored, not counted
    queue_req(CMD_PUSH, 4'hF, '1, '1, 1'b0);
    queue_req(CMD_PUSH, 4'h1, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b0);
    queue_req(CMD_PUSH, 4'h1, 32'h0000_0001, 32'h8000_0000, 1'b0);
    queue_req(CMD_QUERY, 4'h0, '1, '1, 1'b0);
    queue_req(CMD_QUERY, 4'hF, '0, '0, 1'b0);
    queue_req(CMD_QUERY, 4'h1, '0, '0, 1'b0);
    queue_req(CMD_QUERY, 4'h7, '0, '0, 1'b0);
    queue_req(CMD_SPARE, 4'hF, '1, '1, 1'b0);
    for (int i = 0; i < 5; i++) queue_req(CMD_POP, 4'hF, '1, '1, 1'b0);
    queue_req(CMD_SPARE, 4'h0, '0, '0, 1'b0);
    queue_req(CMD_QUERY, 4'h0, '0, '0, 1'b1);

    // Random: chunks biased towards filling, draining or neither
    left = 0;
    mode = 0;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (left == 0) begin
        mode = $urandom_range(0, 2);
        left = $urandom_range(20, 60);
      end
      left--;
      push_pct = (mode == 0) ? 65 : (mode == 1) ? 20 : 40;
      pop_pct = (mode == 0) ? 20 : (mode == 1) ? 65 : 40;
      pick = $urandom_range(0, 99);
      if (pick < push_pct) c = CMD_PUSH;
      else if (pick < push_pct + pop_pct) c = CMD_POP;
      else if (pick < 97) c = CMD_QUERY;
      else c = CMD_SPARE;
      // keep clear of overflow until the very end
      if (c == CMD_PUSH && gen_fill >= DEPTH) c = CMD_POP;
      queue_req(c, ID_W'($urandom), rand_word(), rand_word(), (n % 90) == 89);
    end

    // Full sweep: fill to the brim, read back every entry, then one pop on empty
    while (gen_fill < DEPTH) queue_req(CMD_PUSH, ID_W'($urandom), rand_word(), rand_word(), 1'b0);
    queue_req(CMD_QUERY, 4'h0, '0, '0, 1'b0);
    while (gen_fill > 0) queue_req(CMD_POP, ID_W'($urandom), rand_word(), rand_word(), 1'b0);
    queue_req(CMD_POP, 4'h0, '0, '0, 1'b0);

    // Tail, without idling: fill up, overflow, then every cmd while halted
    tail_len = DEPTH - gen_fill + 6;
    while (gen_fill < DEPTH) queue_req(CMD_PUSH, ID_W'($urandom), rand_word(), rand_word(), 1'b0);
    queue_req(CMD_QUERY, 4'h0, '0, '0, 1'b1);
    queue_req(CMD_PUSH, 4'h3, rand_word(), rand_word(), 1'b0);
    queue_req(CMD_PUSH, 4'h5, rand_word(), rand_word(), 1'b0);
    queue_req(CMD_POP, 4'h0, '0, '0, 1'b0);
    queue_req(CMD_QUERY, 4'h0, '0, '0, 1'b0);
    queue_req(CMD_SPARE, 4'hA, '1, '1, 1'b0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (stim_q.size() != 0 || in_valid || awaited_replies.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (err_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

>>> timestamped_event_fifo_top.f
src/tef_pkg.sv
src/tef_mem.sv
src/tef_ctrl.sv
src/tef_out.sv
src/timestamped_event_fifo_top.sv
dv/tb_top.sv
